[hw/rtl/lkvc_pkg.sv]
`default_nettype none
package lkvc_pkg;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned CAP_W = 5;
	localparam int unsigned APB_ADDR_W = 3;
	localparam int unsigned APB_DATA_W = 32;

	typedef logic signed [DATA_W-1:0] word_t;
	typedef logic [CAP_W-1:0] cap_t;

	localparam cap_t CAP_RESET = 5'd16;
	localparam word_t MISS_VALUE = '1;

	// register index, taken from paddr above the byte offset
	localparam logic REG_CAPACITY = 1'b0;

	typedef struct packed {
		logic accept;
		logic commit;
		logic out_pop;
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_valid;
	} ctrl_sts_t;

endpackage
`default_nettype wire

[hw/rtl/lkvc_req_if.sv]
`default_nettype none
interface lkvc_req_if;
	import lkvc_pkg::*;

	logic  valid;
	logic  ready;
	logic  mode;
	word_t key;
	word_t value;

	modport source (output valid, output mode, output key, output value, input ready);
	modport sink (input valid, input mode, input key, input value, output ready);

endinterface
`default_nettype wire

[hw/rtl/lkvc_rsp_if.sv]
`default_nettype none
interface lkvc_rsp_if;
	import lkvc_pkg::*;

	logic  valid;
	logic  ready;
	logic  hit;
	word_t read_value;
	logic  evicted;
	word_t evicted_key;

	modport source (output valid, output hit, output read_value, output evicted,
		output evicted_key, input ready);
	modport sink (input valid, input hit, input read_value, input evicted,
		input evicted_key, output ready);

endinterface
`default_nettype wire

[hw/rtl/lkvc_ram.sv]
`default_nettype none
module lkvc_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

[hw/rtl/lkvc_ctrl.sv]
`default_nettype none
module lkvc_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 req_valid,
	output logic                      req_ready,
	input  wire logic                 rsp_ready,
	input  wire lkvc_pkg::ctrl_sts_t  sts,
	output lkvc_pkg::ctrl_cmd_t       cmd
);
	import lkvc_pkg::*;

	localparam logic [0:0] ST_IDLE = 1'b0;
	localparam logic [0:0] ST_UPD  = 1'b1;

	logic [0:0] state_q;
	logic       out_free;

	assign req_ready   = (state_q == ST_IDLE);
	assign out_free    = !sts.out_valid || rsp_ready;
	assign cmd.accept  = req_valid && req_ready;
	assign cmd.commit  = (state_q == ST_UPD) && out_free;
	assign cmd.out_pop = sts.out_valid && rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.accept) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					// hold here until the result register can take the result
					if (cmd.commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_accept_then_update: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> (state_q == ST_UPD))
		else $error("accepted item did not move to update");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(sts.out_valid && !rsp_ready) |-> !cmd.commit)
		else $error("commit over a waiting result");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_UPD) && !cmd.commit) |=> (state_q == ST_UPD))
		else $error("update left without commit");

endmodule
`default_nettype wire

[hw/rtl/lkvc_datapath.sv]
`default_nettype none
module lkvc_datapath #(
	parameter int unsigned MAX_ENTRIES = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire lkvc_pkg::ctrl_cmd_t  cmd,
	output lkvc_pkg::ctrl_sts_t       sts,
	input  wire logic                 clear,
	input  wire lkvc_pkg::cap_t       capacity,
	input  wire logic                 in_mode,
	input  wire lkvc_pkg::word_t      in_key,
	input  wire lkvc_pkg::word_t      in_value,
	output logic                      out_hit,
	output lkvc_pkg::word_t           out_read_value,
	output logic                      out_evicted,
	output lkvc_pkg::word_t           out_evicted_key
);
	import lkvc_pkg::*;

	localparam int unsigned IW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int unsigned OW   = $clog2(MAX_ENTRIES + 1);
	localparam int unsigned CMPW = (OW > CAP_W) ? OW : CAP_W;

	// slot state
	word_t                  key_q  [MAX_ENTRIES];
	logic [IW-1:0]          rank_q [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] valid_q;
	logic [OW-1:0]          occ_q;

	// lookup results, taken at the accepting edge
	logic                   mode_s1;
	word_t                  key_s1;
	word_t                  value_s1;
	logic [MAX_ENTRIES-1:0] match_s1;
	logic                   hit_s1;
	logic [IW-1:0]          hit_idx_s1;
	logic [IW-1:0]          hit_rank_s1;
	logic [MAX_ENTRIES-1:0] lru_s1;
	logic [MAX_ENTRIES-1:0] free_s1;
	logic                   full_s1;

	logic                   out_valid_q;
	logic                   out_hit_q;
	word_t                  out_read_value_q;
	logic                   out_evicted_q;
	word_t                  out_evicted_key_q;

	logic [MAX_ENTRIES-1:0] match;
	logic [IW-1:0]          hit_idx;
	logic [IW-1:0]          hit_rank;
	logic [MAX_ENTRIES-1:0] lru;
	logic [MAX_ENTRIES-1:0] free;
	logic [OW-1:0]          occ_m1;
	logic [IW-1:0]          oldest_rank;
	logic [CMPW-1:0]        cap_ext;
	logic [CMPW-1:0]        cap_eff;
	logic                   full;

	logic [MAX_ENTRIES-1:0] tgt;
	logic [IW-1:0]          tgt_idx;
	word_t                  lru_key;
	logic                   insert;
	word_t                  ram_rdata;

	// the oldest valid slot holds rank occupancy-1
	assign occ_m1      = occ_q - OW'(1);
	assign oldest_rank = occ_m1[IW-1:0];

	always_comb begin
		match    = '0;
		hit_idx  = '0;
		hit_rank = '0;
		lru      = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			match[i] = valid_q[i] && (key_q[i] == in_key);
			lru[i]   = valid_q[i] && (rank_q[i] == oldest_rank);
			if (match[i]) begin
				hit_idx  = hit_idx | IW'(i);
				hit_rank = hit_rank | rank_q[i];
			end
		end
	end

	// lowest empty slot
	assign free = ~valid_q & (valid_q + MAX_ENTRIES'(1));

	always_comb begin
		cap_ext = CMPW'(capacity);
		if (capacity == '0) begin
			cap_eff = CMPW'(1);
		end else if (cap_ext > CMPW'(MAX_ENTRIES)) begin
			cap_eff = CMPW'(MAX_ENTRIES);
		end else begin
			cap_eff = cap_ext;
		end
	end

	assign full = CMPW'(occ_q) >= cap_eff;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			mode_s1     <= in_mode;
			key_s1      <= in_key;
			value_s1    <= in_value;
			match_s1    <= match;
			hit_s1      <= |match;
			hit_idx_s1  <= hit_idx;
			hit_rank_s1 <= hit_rank;
			lru_s1      <= lru;
			free_s1     <= free;
			full_s1     <= full;
		end
	end

	assign insert = mode_s1 && !hit_s1;
	assign tgt    = full_s1 ? lru_s1 : free_s1;

	always_comb begin
		tgt_idx = '0;
		lru_key = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			if (tgt[i]) begin
				tgt_idx = tgt_idx | IW'(i);
			end
			if (lru_s1[i]) begin
				lru_key = lru_key | key_q[i];
			end
		end
	end

	lkvc_ram #(
		.WIDTH (DATA_W),
		.DEPTH (MAX_ENTRIES)
	) u_value_ram (
		.clk   (clk),
		.we    (cmd.commit && mode_s1),
		.waddr (hit_s1 ? hit_idx_s1 : tgt_idx),
		.wdata (value_s1),
		.re    (cmd.accept),
		.raddr (hit_idx),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			if (cmd.commit && insert && tgt[i]) begin
				key_q[i] <= key_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rank_q  <= '{default: '0};
			occ_q   <= '0;
		end else if (clear) begin
			valid_q <= '0;
			occ_q   <= '0;
		end else if (cmd.commit) begin
			if (hit_s1) begin
				for (int i = 0; i < MAX_ENTRIES; i++) begin
					if (match_s1[i]) begin
						rank_q[i] <= '0;
					end else if (valid_q[i] && (rank_q[i] < hit_rank_s1)) begin
						rank_q[i] <= rank_q[i] + IW'(1);
					end
				end
			end else if (mode_s1) begin
				// an evicted slot is reused in place, so occupancy only grows when not full
				for (int i = 0; i < MAX_ENTRIES; i++) begin
					if (tgt[i]) begin
						valid_q[i] <= 1'b1;
						rank_q[i]  <= '0;
					end else if (valid_q[i]) begin
						rank_q[i] <= rank_q[i] + IW'(1);
					end
				end
				if (!full_s1) begin
					occ_q <= occ_q + OW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (cmd.out_pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_hit_q         <= hit_s1;
			out_read_value_q  <= mode_s1 ? '0 : (hit_s1 ? ram_rdata : MISS_VALUE);
			out_evicted_q     <= insert && full_s1;
			out_evicted_key_q <= (insert && full_s1) ? lru_key : '0;
		end
	end

	assign sts.out_valid   = out_valid_q;
	assign out_hit         = out_hit_q;
	assign out_read_value  = out_read_value_q;
	assign out_evicted     = out_evicted_q;
	assign out_evicted_key = out_evicted_key_q;

	a_occ_counts_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(occ_q))
		else $error("occupancy does not match valid slots");

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(occ_q) <= int'(MAX_ENTRIES))
		else $error("occupancy above slot count");

	a_single_match: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && hit_s1) |-> $onehot(match_s1))
		else $error("key present in more than one slot");

	a_single_victim: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && insert) |-> $onehot(tgt))
		else $error("insert target not a single slot");

endmodule
`default_nettype wire

[hw/rtl/lru_key_value_cache_unit.sv]
// a transfer registers the lookup; the result enters the output register once free
// a new request waits for the last to commit, set by the compare-then-update sequence
// over the slot registers and the value ram read in the compare cycle
// a finished result waits in its register while the next request is taken
// reset: asynchronous, clears all slots, occupancy and recency; capacity returns to 16
// a capacity write also empties the store in the same cycle
`default_nettype none
module lru_key_value_cache_unit #(
	parameter int unsigned MAX_ENTRIES = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	lkvc_req_if.sink                                   req,
	lkvc_rsp_if.source                                 rsp,
	input  wire logic                                  psel,
	input  wire logic                                  penable,
	input  wire logic                                  pwrite,
	input  wire logic [lkvc_pkg::APB_ADDR_W-1:0]       paddr,
	input  wire logic [lkvc_pkg::APB_DATA_W-1:0]       pwdata,
	output logic      [lkvc_pkg::APB_DATA_W-1:0]       prdata,
	output logic                                       pready
);
	import lkvc_pkg::*;

	cap_t       cap_q;
	logic       cfg_wr;
	logic       clear;
	ctrl_cmd_t  cmd;
	ctrl_sts_t  sts;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign clear  = cfg_wr && (paddr[2] == REG_CAPACITY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (clear) begin
			cap_q <= pwdata[CAP_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_CAPACITY) ? APB_DATA_W'(cap_q) : '0;

	lkvc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	lkvc_datapath #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.clear           (clear),
		.capacity        (cap_q),
		.in_mode         (req.mode),
		.in_key          (req.key),
		.in_value        (req.value),
		.out_hit         (rsp.hit),
		.out_read_value  (rsp.read_value),
		.out_evicted     (rsp.evicted),
		.out_evicted_key (rsp.evicted_key)
	);

	assign rsp.valid = sts.out_valid;

endmodule
`default_nettype wire

[sim/lkvc_checker.sv]
`timescale 1ns / 1ps
module lkvc_checker #(
	parameter int unsigned MAX_ENTRIES = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	lkvc_req_if                                  req,
	lkvc_rsp_if                                  rsp,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [lkvc_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [lkvc_pkg::APB_DATA_W-1:0] pwdata,
	input  wire logic                            pready,
	output int                                   errors,
	output int                                   pending
);
	import lkvc_pkg::*;

	typedef struct packed {
		logic  hit;
		word_t read_value;
		logic  evicted;
		word_t evicted_key;
	} cache_reply_t;

	// shadow copy of the store
	cap_t       capacity;
	word_t      shadow_key [MAX_ENTRIES];
	word_t      shadow_value [MAX_ENTRIES];
	logic       shadow_valid [MAX_ENTRIES];
	logic [3:0] shadow_rank [MAX_ENTRIES];
	int         fill;

	cache_reply_t replies_due [$];

	task automatic empty_store();
		int i;
		for (i = 0; i < MAX_ENTRIES; i++) begin
			shadow_key[i] = '0;
			shadow_value[i] = '0;
			shadow_valid[i] = 1'b0;
			shadow_rank[i] = '0;
		end
		fill = 0;
	endtask

	function automatic int usable_entries();
		if (capacity == 0)
			return 1;
		if (capacity > MAX_ENTRIES)
			return MAX_ENTRIES;
		return capacity;
	endfunction

	function automatic cache_reply_t apply_request(input logic put, input word_t k,
		input word_t v);
		cache_reply_t r;
		int i;
		int s;
		int t;
		logic [3:0] old_rank;
		logic [3:0] oldest;
		r.hit = 1'b0;
		r.read_value = '0;
		r.evicted = 1'b0;
		r.evicted_key = '0;
		s = -1;
		for (i = 0; i < MAX_ENTRIES; i++)
			if (s < 0 && shadow_valid[i] && shadow_key[i] == k)
				s = i;
		if (s >= 0) begin
			r.hit = 1'b1;
			if (put)
				shadow_value[s] = v;
			else
				r.read_value = shadow_value[s];
			// age the entries that were more recent, then move this one to the front
			old_rank = shadow_rank[s];
			for (i = 0; i < MAX_ENTRIES; i++)
				if (shadow_valid[i] && i != s && shadow_rank[i] < old_rank)
					shadow_rank[i]++;
			shadow_rank[s] = '0;
		end else if (!put) begin
			r.read_value = MISS_VALUE;
		end else begin
			t = -1;
			oldest = '0;
			if (fill >= usable_entries()) begin
				for (i = 0; i < MAX_ENTRIES; i++)
					if (shadow_valid[i] && (t < 0 || shadow_rank[i] > oldest)) begin
						t = i;
						oldest = shadow_rank[i];
					end
				if (t >= 0) begin
					r.evicted = 1'b1;
					r.evicted_key = shadow_key[t];
					shadow_valid[t] = 1'b0;
					fill--;
				end
			end
			if (t < 0)
				for (i = MAX_ENTRIES - 1; i >= 0; i--)
					if (!shadow_valid[i])
						t = i;
			if (t >= 0) begin
				for (i = 0; i < MAX_ENTRIES; i++)
					if (shadow_valid[i])
						shadow_rank[i]++;
				shadow_valid[t] = 1'b1;
				shadow_key[t] = k;
				shadow_value[t] = v;
				shadow_rank[t] = '0;
				fill++;
			end
		end
		return r;
	endfunction

	task automatic flag_mismatch(input string what, input cache_reply_t want,
		input cache_reply_t got);
		errors++;
		if (errors <= 10) begin
			$display("[%0t] %s: expected hit=%0b read_value=%0d evicted=%0b evicted_key=%0d",
				$realtime, what, want.hit, want.read_value, want.evicted, want.evicted_key);
			$display("[%0t] %s:      got hit=%0b read_value=%0d evicted=%0b evicted_key=%0d",
				$realtime, what, got.hit, got.read_value, got.evicted, got.evicted_key);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		cache_reply_t seen;
		cache_reply_t want;
		if (!arst_n) begin
			capacity = CAP_RESET;
			empty_store();
			replies_due.delete();
			errors = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				seen.hit = rsp.hit;
				seen.read_value = rsp.read_value;
				seen.evicted = rsp.evicted;
				seen.evicted_key = rsp.evicted_key;
				if (replies_due.size() == 0) begin
					flag_mismatch("result with no request outstanding", seen, seen);
				end else begin
					want = replies_due.pop_front();
					if (seen.hit !== want.hit || seen.read_value !== want.read_value ||
						seen.evicted !== want.evicted || seen.evicted_key !== want.evicted_key)
						flag_mismatch("result mismatch", want, seen);
				end
			end
			if (psel && penable && pwrite && pready && paddr[2] == REG_CAPACITY) begin
				capacity = pwdata[CAP_W-1:0];
				empty_store();
			end
			if (req.valid && req.ready)
				replies_due.push_back(apply_request(req.mode, req.key, req.value));
		end
		pending = replies_due.size();
	end

endmodule

[sim/lru_key_value_cache_unit_tb.sv]
`timescale 1ns / 1ps
module lru_key_value_cache_unit_tb;
	import lkvc_pkg::*;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	int                    errors;
	int                    pending;

	int unsigned req_idle_pct;
	int unsigned rsp_idle_pct;
	int          requests_sent;
	int          capacity_writes;
	cap_t        capacity_now;

	lkvc_req_if req_ch ();
	lkvc_rsp_if rsp_ch ();

	lru_key_value_cache_unit i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	lkvc_checker i_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.pready  (pready),
		.errors  (errors),
		.pending (pending)
	);

	always #5 clk = ~clk;

	initial begin
		#5_000_000;
		$display("TEST FAILED");
		$finish;
	end

	// result side back-pressure
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
		end
	end

	task automatic set_pacing(input int phase);
		case (phase)
			0: begin
				req_idle_pct = 20;
				rsp_idle_pct = 88;
			end
			1: begin
				req_idle_pct = 88;
				rsp_idle_pct = 20;
			end
			default: begin
				req_idle_pct = 0;
				rsp_idle_pct = 0;
			end
		endcase
	endtask

	task automatic send_request(input logic put, input word_t k, input word_t v);
		while ($urandom_range(99) < req_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.mode <= put;
		req_ch.key <= k;
		req_ch.value <= v;
		do
			@(posedge clk);
		while (!req_ch.ready);
		requests_sent++;
	endtask

	// hold the request side until every result is back, then let the block settle
	task automatic drain();
		req_ch.valid <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_capacity(input cap_t cap);
		drain();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_CAPACITY, 2'b00};
		pwdata <= APB_DATA_W'(cap);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		capacity_now = cap;
		capacity_writes++;
	endtask

	function automatic int usable_entries(input cap_t cap);
		if (cap == 0)
			return 1;
		if (cap > 16)
			return 16;
		return cap;
	endfunction

	// mostly keys from a small pool just above base so hits and evictions are common
	function automatic word_t pick_key(input word_t base, input int unsigned span);
		if ($urandom_range(15) == 0)
			return word_t'($urandom);
		return base + word_t'($urandom_range(span - 1));
	endfunction

	initial begin
		cap_t  seg_caps [9];
		word_t base;
		int    seg;
		int    n;
		int    span;
		seg_caps = '{5'd16, 5'd1, 5'd4, 5'd31, 5'd8, 5'd0, 5'd16, 5'd3, 5'd12};
		req_ch.valid = 1'b0;
		req_ch.mode = 1'b0;
		req_ch.key = '0;
		req_ch.value = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		requests_sent = 0;
		capacity_writes = 0;
		capacity_now = CAP_RESET;
		set_pacing(0);
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset capacity, extreme keys and values
		send_request(1'b0, 32'sd0, 32'sd0);
		send_request(1'b1, 32'sh8000_0000, 32'sh7fff_ffff);
		send_request(1'b1, 32'sh7fff_ffff, 32'sh8000_0000);
		send_request(1'b1, -32'sd1, -32'sd1);
		send_request(1'b1, 32'sd0, 32'sd0);
		send_request(1'b0, 32'sh8000_0000, 32'sd0);
		send_request(1'b0, -32'sd1, 32'sd0);
		send_request(1'b1, 32'sh7fff_ffff, 32'sh1234_5678);
		send_request(1'b0, 32'sh7fff_ffff, 32'shffff_ffff);
		send_request(1'b0, 32'sd5, 32'sd9);

		// two entries: lru order follows gets and updates
		write_capacity(5'd2);
		send_request(1'b1, 32'sd1, 32'sd100);
		send_request(1'b1, 32'sd2, 32'sd200);
		send_request(1'b0, 32'sd1, 32'sd0);
		send_request(1'b1, 32'sd3, 32'sd300);
		send_request(1'b0, 32'sd2, 32'sd0);
		send_request(1'b1, 32'sd1, 32'sd111);
		send_request(1'b1, 32'sd4, 32'sd400);

		// zero capacity behaves as a single entry
		write_capacity(5'd0);
		send_request(1'b1, 32'sd7, 32'sd70);
		send_request(1'b1, 32'sd8, 32'sd80);
		send_request(1'b0, 32'sd8, 32'sd0);
		send_request(1'b0, 32'sd7, 32'sd0);

		for (seg = 0; seg < 9; seg++) begin
			set_pacing(seg / 3);
			write_capacity(seg_caps[seg]);
			base = word_t'($urandom);
			span = usable_entries(capacity_now) + 4;
			for (n = 0; n < 128; n++) begin
				if ($urandom_range(63) == 0)
					drain();
				send_request($urandom_range(99) < 55, pick_key(base, span), word_t'($urandom));
			end
		end

		req_ch.valid <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
		repeat (10) @(posedge clk);
		$display("%0d requests checked across %0d capacity settings (zero, one, full, oversize)",
			requests_sent, capacity_writes);
		$display("pacing covered slow sender, slow receiver and back-to-back transfer");
		if (errors == 0 && pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/lkvc_pkg.sv
hw/rtl/lkvc_req_if.sv
hw/rtl/lkvc_rsp_if.sv
hw/rtl/lkvc_ram.sv
hw/rtl/lkvc_ctrl.sv
hw/rtl/lkvc_datapath.sv
hw/rtl/lru_key_value_cache_unit.sv
sim/lkvc_checker.sv
sim/lru_key_value_cache_unit_tb.sv
